// ----- src/ksto_pkg.sv -----
// Shared types and constants for the keyed slot table.
// Used by ksto_cell and keyed_slot_table_with_offline_eviction; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ksto_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned IDX_W     = 6;

  localparam logic [2:0] OFFLINE_STATUS = 3'd6;

  typedef enum logic [2:0] {
    OUT_HIT      = 3'd0,
    OUT_NEW      = 3'd1,
    OUT_REPLACED = 3'd2,
    OUT_REJECTED = 3'd3,
    OUT_REMOVED  = 3'd4,
    OUT_MISS     = 3'd5
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        used;
    logic [63:0] key;
    logic [2:0]  status;
    logic [31:0] rtime;
  } entry_t;

  typedef struct packed {
    logic        mode;
    logic [63:0] agent_key;
    logic [2:0]  new_status;
    logic [31:0] rx_time;
  } in_t;

  typedef struct packed {
    logic [2:0]       outcome;
    logic [IDX_W-1:0] slot_index;
  } out_t;

endpackage

`default_nettype wire

// ----- src/ksto_cell.sv -----
// One slot of the rotating slot ring: holds one table entry and passes it on.
// Depends on ksto_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module ksto_cell
  import ksto_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   shift_i,
  input  wire entry_t entry_i,
  output entry_t      entry_o
);

  entry_t entry_q;

  // The table resets to all zero, so every field of the entry is cleared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ----- src/keyed_slot_table_with_offline_eviction.sv -----
// Top level of the keyed slot table: slot ring, scan controller and output register.
// Depends on ksto_pkg and ksto_cell.
`timescale 1ns / 1ps
`default_nettype none

// The table keeps SLOTS entries in a ring of cells that rotates by one slot per
// cycle while a scan or write pass runs, past a single inspection point, so every
// slot is seen once per pass and the ring is back in place at the end of a pass.
// An item is taken only while the controller is idle. A remove takes one pass
// (clearing matching slots as they go by), and its result is then registered from
// the done state. An update takes one pass to find a hit, the lowest free slot and
// the oldest offline slot, then a second pass to write the chosen slot. An update
// with the empty key skips both passes and goes straight to the done state; one
// that finds no slot to use skips the write pass. The controller goes back to idle
// as the result is registered, so the next item can be taken in the cycle after,
// as long as the output register was free; while a finished result still waits
// there, the controller holds. The ring rotation is what sets the item time.
module keyed_slot_table_with_offline_eviction
  import ksto_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  entry_t ring [SLOTS];
  entry_t wb;
  logic   shift;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      ksto_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .entry_i (wb),
        .entry_o (ring[i])
      );
    end else begin : g_body
      ksto_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .entry_i (ring[i+1]),
        .entry_o (ring[i])
      );
    end
  end

  state_e state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;
  in_t item_q, item_d;

  logic hit_q, hit_d;
  logic free_q, free_d;
  logic vic_q, vic_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  logic [IW-1:0] vic_idx_q, vic_idx_d;
  logic [31:0] vic_time_q, vic_time_d;
  logic [IW-1:0] tgt_q, tgt_d;
  outcome_e res_q, res_d;
  logic [IW-1:0] res_idx_q, res_idx_d;

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  entry_t head;
  logic   match;

  assign head  = ring[0];
  assign match = head.used && (head.key == item_q.agent_key);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    hit_q      <= hit_d;
    free_q     <= free_d;
    vic_q      <= vic_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    vic_idx_q  <= vic_idx_d;
    vic_time_q <= vic_time_d;
    tgt_q      <= tgt_d;
    res_q      <= res_d;
    res_idx_q  <= res_idx_d;
    out_q      <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    item_d      = item_q;
    hit_d       = hit_q;
    free_d      = free_q;
    vic_d       = vic_q;
    hit_idx_d   = hit_idx_q;
    free_idx_d  = free_idx_q;
    vic_idx_d   = vic_idx_q;
    vic_time_d  = vic_time_q;
    tgt_d       = tgt_q;
    res_d       = res_q;
    res_idx_d   = res_idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    shift       = 1'b0;
    wb          = head;
    in_stall_o  = 1'b1;

    // The beat in the output register leaves on its own handshake.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          item_d = in_data_i;
          cnt_d  = '0;
          hit_d  = 1'b0;
          free_d = 1'b0;
          vic_d  = 1'b0;
          if (!in_data_i.mode && (in_data_i.agent_key == 64'd0)) begin
            res_d     = OUT_REJECTED;
            res_idx_d = '0;
            state_d   = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        shift = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (item_q.mode) begin
          // Remove clears matches on the fly; the first one sets the index.
          if (match) begin
            wb = '0;
            if (!hit_q) begin
              hit_d     = 1'b1;
              hit_idx_d = cnt_q;
            end
          end
        end else begin
          if (match && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = cnt_q;
          end
          if (!head.used && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = cnt_q;
          end
          if ((head.status == OFFLINE_STATUS) && (!vic_q || (head.rtime < vic_time_q))) begin
            vic_d      = 1'b1;
            vic_idx_d  = cnt_q;
            vic_time_d = head.rtime;
          end
        end
        if (cnt_q == LAST) begin
          cnt_d = '0;
          if (item_q.mode) begin
            if (hit_d) begin
              res_d     = OUT_REMOVED;
              res_idx_d = hit_idx_d;
            end else begin
              res_d     = OUT_MISS;
              res_idx_d = '0;
            end
            state_d = ST_DONE;
          end else if (hit_d) begin
            res_d   = OUT_HIT;
            tgt_d   = hit_idx_d;
            state_d = ST_APPLY;
          end else if (free_d) begin
            res_d   = OUT_NEW;
            tgt_d   = free_idx_d;
            state_d = ST_APPLY;
          end else if (vic_d) begin
            res_d   = OUT_REPLACED;
            tgt_d   = vic_idx_d;
            state_d = ST_APPLY;
          end else begin
            res_d     = OUT_REJECTED;
            res_idx_d = '0;
            state_d   = ST_DONE;
          end
          res_idx_d = (state_d == ST_APPLY) ? tgt_d : res_idx_d;
        end
      end

      ST_APPLY: begin
        shift = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == tgt_q) begin
          wb.used   = 1'b1;
          wb.key    = item_q.agent_key;
          wb.status = item_q.new_status;
          wb.rtime  = item_q.rx_time;
        end
        if (cnt_q == LAST) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_d) begin
          out_valid_d        = 1'b1;
          out_d.outcome      = res_q;
          out_d.slot_index   = IDX_W'(res_idx_q);
          state_d            = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
